/* rtl/gabb_pkg.sv */
// Shared constants for the glyph atlas bounding-box block: register codes,
// field widths and parameter defaults. No dependencies.
`default_nettype none

package gabb_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int DIM_W       = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);
   localparam int DIM_RESET = 256;

   // parameter defaults
   localparam int GRID_CELLS_DEF    = 16;
   localparam int MAX_IMAGE_DIM_DEF = 4096;
   localparam int QUEUE_DEPTH       = 4;

   // stream payload widths
   localparam int ALPHA_W   = 8;
   localparam int CODE_W    = 8;
   localparam int GLYPH_W_W = 9;
   localparam int GLYPH_H_W = 9;
   localparam int BEAR_X_W  = 8;
   localparam int BEAR_Y_W  = 8;
   localparam int RSP_FIELDS_W = CODE_W + GLYPH_W_W + GLYPH_H_W + BEAR_X_W + BEAR_Y_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/glyph_atlas_bounding_box.sv */
// Glyph atlas bounding-box extractor, top level: front end, queue, back end
// and stream packing. Uses gabb_pkg, gabb_front, gabb_queue and gabb_back.
//
// Takes one atlas alpha byte per clock in raster order and keeps, for each of
// the GRID_CELLS glyph cells of the current cell row, the box of covered
// pixels. The pixel that closes a cell row copies all boxes into a snapshot
// bank; the GRID_CELLS glyph records then leave one per clock while
// rsp_tready is high, through the output register, the last one flagged
// by rsp_tlast. The pixel path takes one transaction per clock; req_tready
// drops only when the four-entry queue fills. The back end sends all
// records of a cell row before it takes the next snapshot, so the queue
// fills when records are held back by rsp_tready, or with one-pixel cells
// in an atlas GRID_CELLS pixels wide, where a row closes every GRID_CELLS
// pixels and the input stalls once the queue is full. rsp_tvalid rises
// once the closing pixel has passed the queue, the snapshot bank and the
// output register. A write to either dimension register restarts the frame
// at pixel 0 and is always taken; write only while the block is idle.
`default_nettype none

module glyph_atlas_bounding_box #(
   parameter int GRID_CELLS    = gabb_pkg::GRID_CELLS_DEF,
   parameter int MAX_IMAGE_DIM = gabb_pkg::MAX_IMAGE_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gabb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gabb_pkg::DIM_W-1:0]       csr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [gabb_pkg::ALPHA_W-1:0]     req_tdata,   // alpha
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // glyph_code, glyph_width, glyph_height, bearing_x, bearing_y, zero pad
   output logic [gabb_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast    // last_of_row
);

   import gabb_pkg::*;

   localparam int IDX_W  = $clog2(GRID_CELLS);
   localparam int CELL_W = $clog2(MAX_IMAGE_DIM / GRID_CELLS + 1);
   localparam int ITEM_W = 2 + 2 * IDX_W + 2 * CELL_W;
   localparam int PAD_W  = RSP_DATA_W - RSP_FIELDS_W;

   logic              push_valid, push_ready, pop_valid, pop_ready, restart;
   logic [ITEM_W-1:0] push_item, pop_item;
   logic [CELL_W-1:0] cell_w;
   logic [CODE_W-1:0]    glyph_code;
   logic [GLYPH_W_W-1:0] glyph_width;
   logic [GLYPH_H_W-1:0] glyph_height;
   logic [BEAR_X_W-1:0]  bearing_x;
   logic [BEAR_Y_W-1:0]  bearing_y;

   gabb_front #(
      .GRID_CELLS    (GRID_CELLS),
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
      .ITEM_W        (ITEM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .alpha      (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .cell_w     (cell_w),
      .restart    (restart)
   );

   gabb_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_item)
   );

   gabb_back #(
      .GRID_CELLS    (GRID_CELLS),
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
      .ITEM_W        (ITEM_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .cell_w       (cell_w),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_item     (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .glyph_code   (glyph_code),
      .glyph_width  (glyph_width),
      .glyph_height (glyph_height),
      .bearing_x    (bearing_x),
      .bearing_y    (bearing_y),
      .last_of_row  (rsp_tlast)
   );

   assign rsp_tdata = {PAD_W'(0), bearing_y, bearing_x, glyph_height, glyph_width, glyph_code};

endmodule

`default_nettype wire

/* rtl/gabb_queue.sv */
// Small register FIFO between the pixel front end and the box back end.
// Depends on nothing but its parameters.
`default_nettype none

module gabb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/gabb_front.sv */
// Front end: configuration registers, raster position counters and cell
// classification of each pixel. Uses gabb_pkg.
`default_nettype none

module gabb_front #(
   parameter int GRID_CELLS    = gabb_pkg::GRID_CELLS_DEF,
   parameter int MAX_IMAGE_DIM = gabb_pkg::MAX_IMAGE_DIM_DEF,
   parameter int ITEM_W        = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gabb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gabb_pkg::DIM_W-1:0]       csr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [gabb_pkg::ALPHA_W-1:0]     alpha,
   output logic                                  push_valid,
   input  wire logic                             push_ready,
   output logic [ITEM_W-1:0]                     push_item,
   output logic [$clog2(MAX_IMAGE_DIM/GRID_CELLS+1)-1:0] cell_w,
   output logic                                  restart
);

   import gabb_pkg::*;

   localparam int IDX_W  = $clog2(GRID_CELLS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CELL_W = $clog2(MAX_IMAGE_DIM / GRID_CELLS + 1);
   localparam int POS_W  = $clog2(MAX_IMAGE_DIM);
   localparam int DIMV_W = $clog2(MAX_IMAGE_DIM + 1);
   // exact floor division by GRID_CELLS through a rounded-up reciprocal
   localparam int RECIP_K = DIMV_W + IDX_W;
   localparam int RECIP_M = (2 ** RECIP_K + GRID_CELLS - 1) / GRID_CELLS;
   localparam int PROD_W  = DIMV_W + RECIP_K + 1;
   localparam int DIM_RST_EFF = (DIM_RESET > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : DIM_RESET;
   localparam int CELL_RST    = DIM_RST_EFF / GRID_CELLS;

   typedef struct packed {
      logic              covered;
      logic              close;
      logic [IDX_W-1:0]  col_idx;
      logic [IDX_W-1:0]  row;
      logic [CELL_W-1:0] cx;
      logic [CELL_W-1:0] cy;
   } item_type;

   logic [DIMV_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [CELL_W-1:0] cw_ff, cw_in, ch_ff, ch_in;
   logic [POS_W-1:0]  col_ff, col_in, line_ff, line_in;
   logic [CELL_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CNT_W-1:0]  cc_ff, cc_in, row_ff, row_in;
   logic [DIMV_W-1:0] csr_eff;
   logic [PROD_W-1:0] csr_prod;
   logic [CELL_W-1:0] csr_cell;
   logic              accept, in_grid, close, col_end, line_end;
   item_type          item;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign cell_w     = cw_ff;

   // clamp to the largest supported dimension, then divide by the grid size
   always_comb begin
      csr_eff  = (32'(csr_data) > 32'(MAX_IMAGE_DIM)) ? DIMV_W'(MAX_IMAGE_DIM)
                                                     : DIMV_W'(csr_data);
      csr_prod = PROD_W'(csr_eff) * PROD_W'(RECIP_M);
      csr_cell = CELL_W'(csr_prod >> RECIP_K);
   end

   always_comb begin
      in_grid = (cw_ff != '0) && (ch_ff != '0) &&
                (cc_ff < CNT_W'(GRID_CELLS)) && (row_ff < CNT_W'(GRID_CELLS));
      close  = (cc_ff == CNT_W'(GRID_CELLS - 1)) &&
               (CELL_W'(cx_ff + 1'b1) == cw_ff) && (CELL_W'(cy_ff + 1'b1) == ch_ff);
      col_end  = (32'(col_ff) + 32'd1) >= 32'(w_ff);
      line_end = (32'(line_ff) + 32'd1) >= 32'(h_ff);

      item.covered = (alpha != '0);
      item.close   = close;
      item.col_idx = cc_ff[IDX_W-1:0];
      item.row     = row_ff[IDX_W-1:0];
      item.cx      = cx_ff;
      item.cy      = cy_ff;
      push_item    = item;
      // only pixels that can change a box or close a cell row go on
      push_valid   = accept && in_grid && (item.covered || close);
   end

   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      cw_in   = cw_ff;
      ch_in   = ch_ff;
      col_in  = col_ff;
      line_in = line_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cc_in   = cc_ff;
      row_in  = row_ff;
      restart = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               w_in    = csr_eff;
               cw_in   = csr_cell;
               restart = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               h_in    = csr_eff;
               ch_in   = csr_cell;
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end

      if (restart) begin
         col_in  = '0;
         line_in = '0;
         cx_in   = '0;
         cy_in   = '0;
         cc_in   = '0;
         row_in  = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            cx_in  = '0;
            cc_in  = '0;
            if (line_end) begin
               line_in = '0;
               cy_in   = '0;
               row_in  = '0;
            end else begin
               line_in = POS_W'(line_ff + 1'b1);
               if (row_ff < CNT_W'(GRID_CELLS)) begin
                  if (CELL_W'(cy_ff + 1'b1) == ch_ff) begin
                     cy_in  = '0;
                     row_in = CNT_W'(row_ff + 1'b1);
                  end else begin
                     cy_in = CELL_W'(cy_ff + 1'b1);
                  end
               end
            end
         end else begin
            col_in = POS_W'(col_ff + 1'b1);
            if (cc_ff < CNT_W'(GRID_CELLS)) begin
               if (CELL_W'(cx_ff + 1'b1) == cw_ff) begin
                  cx_in = '0;
                  cc_in = CNT_W'(cc_ff + 1'b1);
               end else begin
                  cx_in = CELL_W'(cx_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= DIMV_W'(DIM_RST_EFF);
         h_ff    <= DIMV_W'(DIM_RST_EFF);
         cw_ff   <= CELL_W'(CELL_RST);
         ch_ff   <= CELL_W'(CELL_RST);
         col_ff  <= '0;
         line_ff <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         cc_ff   <= '0;
         row_ff  <= '0;
      end else begin
         w_ff    <= w_in;
         h_ff    <= h_in;
         cw_ff   <= cw_in;
         ch_ff   <= ch_in;
         col_ff  <= col_in;
         line_ff <= line_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cc_ff   <= cc_in;
         row_ff  <= row_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/gabb_back.sv */
// Back end: per-cell bounding boxes of the current cell row, a snapshot bank
// taken when the row closes, and the glyph record output register. Uses gabb_pkg.
`default_nettype none

module gabb_back #(
   parameter int GRID_CELLS    = gabb_pkg::GRID_CELLS_DEF,
   parameter int MAX_IMAGE_DIM = gabb_pkg::MAX_IMAGE_DIM_DEF,
   parameter int ITEM_W        = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         restart,
   input  wire logic [$clog2(MAX_IMAGE_DIM/GRID_CELLS+1)-1:0] cell_w,
   input  wire logic                         pop_valid,
   output logic                              pop_ready,
   input  wire logic [ITEM_W-1:0]            pop_item,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [gabb_pkg::CODE_W-1:0]       glyph_code,
   output logic [gabb_pkg::GLYPH_W_W-1:0]    glyph_width,
   output logic [gabb_pkg::GLYPH_H_W-1:0]    glyph_height,
   output logic [gabb_pkg::BEAR_X_W-1:0]     bearing_x,
   output logic [gabb_pkg::BEAR_Y_W-1:0]     bearing_y,
   output logic                              last_of_row
);

   import gabb_pkg::*;

   localparam int IDX_W  = $clog2(GRID_CELLS);
   localparam int CELL_W = $clog2(MAX_IMAGE_DIM / GRID_CELLS + 1);

   typedef struct packed {
      logic              covered;
      logic              close;
      logic [IDX_W-1:0]  col_idx;
      logic [IDX_W-1:0]  row;
      logic [CELL_W-1:0] cx;
      logic [CELL_W-1:0] cy;
   } item_type;

   // max is exclusive, zero marks an empty cell
   logic [CELL_W-1:0] min_x_ff [GRID_CELLS], min_x_in [GRID_CELLS];
   logic [CELL_W-1:0] max_x_ff [GRID_CELLS], max_x_in [GRID_CELLS];
   logic [CELL_W-1:0] min_y_ff [GRID_CELLS], min_y_in [GRID_CELLS];
   logic [CELL_W-1:0] max_y_ff [GRID_CELLS], max_y_in [GRID_CELLS];
   logic [CELL_W-1:0] snap_min_x_ff [GRID_CELLS], snap_min_x_in [GRID_CELLS];
   logic [CELL_W-1:0] snap_max_x_ff [GRID_CELLS], snap_max_x_in [GRID_CELLS];
   logic [CELL_W-1:0] snap_min_y_ff [GRID_CELLS], snap_min_y_in [GRID_CELLS];
   logic [CELL_W-1:0] snap_max_y_ff [GRID_CELLS], snap_max_y_in [GRID_CELLS];
   logic [IDX_W-1:0]  snap_row_ff, snap_row_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [GLYPH_W_W-1:0] gw_ff, gw_in;
   logic [GLYPH_H_W-1:0] gh_ff, gh_in;
   logic [BEAR_X_W-1:0]  bx_ff, bx_in;
   logic [BEAR_Y_W-1:0]  by_ff, by_in;
   logic                 last_ff, last_in;

   item_type          item;
   logic              pop, load, empty;
   logic [CELL_W-1:0] cx_end, cy_end;
   logic [CELL_W-1:0] upd_min_x, upd_max_x, upd_min_y, upd_max_y;
   logic [CELL_W-1:0] e_min_x, e_max_x, e_min_y, e_max_y;
   logic [CELL_W-1:0] rec_w, rec_h, rec_bx, rec_by;

   assign item      = item_type'(pop_item);
   // hold a closing transaction while the previous row is still draining
   assign pop_ready = !(item.close && busy_ff);
   assign pop       = pop_valid && pop_ready;
   assign load      = busy_ff && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid    = rsp_valid_ff;
   assign glyph_code   = code_ff;
   assign glyph_width  = gw_ff;
   assign glyph_height = gh_ff;
   assign bearing_x    = bx_ff;
   assign bearing_y    = by_ff;
   assign last_of_row  = last_ff;

   // merge the pixel into its cell's box
   always_comb begin
      cx_end    = CELL_W'(item.cx + 1'b1);
      cy_end    = CELL_W'(item.cy + 1'b1);
      upd_min_x = min_x_ff[item.col_idx];
      upd_max_x = max_x_ff[item.col_idx];
      upd_min_y = min_y_ff[item.col_idx];
      upd_max_y = max_y_ff[item.col_idx];
      if (item.covered) begin
         if (item.cx < upd_min_x) upd_min_x = item.cx;
         if (cx_end > upd_max_x)  upd_max_x = cx_end;
         if (item.cy < upd_min_y) upd_min_y = item.cy;
         if (cy_end > upd_max_y)  upd_max_y = cy_end;
      end
   end

   // glyph record from the snapshot entry being drained
   always_comb begin
      e_min_x = snap_min_x_ff[idx_ff];
      e_max_x = snap_max_x_ff[idx_ff];
      e_min_y = snap_min_y_ff[idx_ff];
      e_max_y = snap_max_y_ff[idx_ff];
      empty   = (e_max_x == '0);
      if (empty) begin
         rec_w  = cell_w >> 1;
         rec_h  = '0;
         rec_bx = '0;
         rec_by = '0;
      end else begin
         rec_w  = CELL_W'(e_max_x - e_min_x);
         rec_h  = CELL_W'(e_max_y - e_min_y);
         rec_bx = e_min_x;
         rec_by = e_min_y;
      end
   end

   always_comb begin
      min_x_in      = min_x_ff;
      max_x_in      = max_x_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      snap_min_x_in = snap_min_x_ff;
      snap_max_x_in = snap_max_x_ff;
      snap_min_y_in = snap_min_y_ff;
      snap_max_y_in = snap_max_y_ff;
      snap_row_in   = snap_row_ff;
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      code_in       = code_ff;
      gw_in         = gw_ff;
      gh_in         = gh_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      last_in       = last_ff;

      if (restart) begin
         for (int c = 0; c < GRID_CELLS; c++) begin
            min_x_in[c] = '1;
            max_x_in[c] = '0;
            min_y_in[c] = '1;
            max_y_in[c] = '0;
         end
      end else if (pop) begin
         if (item.close) begin
            for (int c = 0; c < GRID_CELLS; c++) begin
               snap_min_x_in[c] = min_x_ff[c];
               snap_max_x_in[c] = max_x_ff[c];
               snap_min_y_in[c] = min_y_ff[c];
               snap_max_y_in[c] = max_y_ff[c];
               min_x_in[c]      = '1;
               max_x_in[c]      = '0;
               min_y_in[c]      = '1;
               max_y_in[c]      = '0;
            end
            snap_min_x_in[item.col_idx] = upd_min_x;
            snap_max_x_in[item.col_idx] = upd_max_x;
            snap_min_y_in[item.col_idx] = upd_min_y;
            snap_max_y_in[item.col_idx] = upd_max_y;
            snap_row_in = item.row;
            busy_in     = 1'b1;
            idx_in      = '0;
         end else begin
            min_x_in[item.col_idx] = upd_min_x;
            max_x_in[item.col_idx] = upd_max_x;
            min_y_in[item.col_idx] = upd_min_y;
            max_y_in[item.col_idx] = upd_max_y;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         code_in = CODE_W'((32'(GRID_CELLS - 1) - 32'(snap_row_ff)) * 32'(GRID_CELLS)
                           + 32'(idx_ff));
         gw_in   = GLYPH_W_W'(rec_w);
         gh_in   = GLYPH_H_W'(rec_h);
         bx_in   = BEAR_X_W'(rec_bx);
         by_in   = BEAR_Y_W'(rec_by);
         last_in = (idx_ff == IDX_W'(GRID_CELLS - 1));
         if (idx_ff == IDX_W'(GRID_CELLS - 1)) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = IDX_W'(idx_ff + 1'b1);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < GRID_CELLS; c++) begin
            min_x_ff[c] <= '1;
            max_x_ff[c] <= '0;
            min_y_ff[c] <= '1;
            max_y_ff[c] <= '0;
         end
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_min_x_ff <= snap_min_x_in;
      snap_max_x_ff <= snap_max_x_in;
      snap_min_y_ff <= snap_min_y_in;
      snap_max_y_ff <= snap_max_y_in;
      snap_row_ff   <= snap_row_in;
      code_ff       <= code_in;
      gw_ff         <= gw_in;
      gh_ff         <= gh_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      last_ff       <= last_in;
   end

endmodule

`default_nettype wire
